/* hw/rtl/secr_pkg.sv */
// Shared types and constants of the stick event command repeater.
package secr_pkg;

    // Field and register widths
    localparam int ACTION_W   = 2;
    localparam int NUMBER_W   = 8;
    localparam int VALUE_W    = 16;
    localparam int CMD_W      = 3;
    localparam int SEEK_W     = 8;
    localparam int VOL_W      = 10;
    localparam int THR_W      = 15;
    localparam int TIME_W     = 16;
    localparam int MAP_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Seek scaling: product of excess (16 bits) and max_seek - 1 (8 bits)
    localparam int PROD_W     = VALUE_W + SEEK_W;
    localparam int MUL_STEPS  = SEEK_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_CNT_W = 5;

    // Register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 15'd12000;
    localparam logic [TIME_W-1:0] WAIT_MS_RST    = 16'd500;
    localparam logic [TIME_W-1:0] REPEAT_MS_RST  = 16'd100;
    localparam logic [SEEK_W-1:0] MAX_SEEK_RST   = 8'd10;
    localparam logic [MAP_W-1:0]  ACTION_MAP_RST = 24'd8423093;

    localparam logic [THR_W-1:0]  AXIS_FULL    = 15'h7FFF;
    localparam logic [TIME_W-1:0] TIME_SAT     = 16'hFFFF;
    localparam int                THR_CHANGE   = 200;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_WAIT_MS    = 3'd1,
        CFG_REPEAT_MS  = 3'd2,
        CFG_MAX_SEEK   = 3'd3,
        CFG_ACTION_MAP = 3'd4
    } cfg_idx_t;

    // Item kinds
    localparam logic [ACTION_W-1:0] ACT_AXIS   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUTTON = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [NUMBER_W-1:0] AXIS_THROTTLE = 8'd2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEEK_FWD  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEEK_BACK = 3'd6;
    localparam logic [CMD_W-1:0] CMD_VOLUME    = 3'd7;

    // Request into the seek scaler
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic [THR_W-1:0]   thr;
        logic [SEEK_W-1:0]  max_seek;
    } seek_req_t;

    // Answer from the seek scaler
    typedef struct packed {
        logic              done;
        logic [SEEK_W-1:0] amount;
    } seek_rsp_t;

endpackage

/* hw/rtl/secr_seek.sv */
// Bit-serial seek amount scaler: shift-add multiply, then restoring divide.
module secr_seek (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  secr_pkg::seek_req_t   req,
    output secr_pkg::seek_rsp_t   rsp
);
    import secr_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIN  = 4'b1000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]       mcand_reg, mcand_next;
    logic [SEEK_W-1:0]       mplier_reg, mplier_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [THR_W-1:0]        den_reg, den_next;
    logic [THR_W-1:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]       dq_reg, dq_next;
    logic [SEEK_W-1:0]       ms_reg, ms_next;

    logic [SEEK_W-1:0]       ms_eff;
    logic [VALUE_W-1:0]      thr_ext;
    logic [PROD_W-1:0]       acc_sum;
    logic [THR_W:0]          rem_sh;
    logic                    q_bit;

    assign ms_eff  = (req.max_seek == '0) ? SEEK_W'(1) : req.max_seek;
    assign thr_ext = {1'b0, req.thr};

    // One multiplier bit and one quotient bit per cycle
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh  = {rem_reg, dq_reg[PROD_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        ms_next     = ms_reg;
        case (phase_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    ms_next = ms_eff;
                    cnt_next = '0;
                    if (req.mag <= thr_ext)
                    begin
                        // inside the dead zone: amount is 1
                        dq_next = '0;
                        phase_next = U_FIN;
                    end
                    else if (req.thr == AXIS_FULL)
                    begin
                        // no span left: amount saturates at max_seek
                        dq_next = '1;
                        phase_next = U_FIN;
                    end
                    else
                    begin
                        mcand_next  = PROD_W'(req.mag - thr_ext);
                        mplier_next = ms_eff - SEEK_W'(1);
                        acc_next    = '0;
                        den_next    = AXIS_FULL - req.thr;
                        phase_next  = U_MUL;
                    end
                end
            end
            U_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[SEEK_W-1:1]};
                cnt_next    = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(MUL_STEPS - 1))
                begin
                    dq_next    = acc_sum;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next = q_bit ? THR_W'(rem_sh - {1'b0, den_reg}) : rem_sh[THR_W-1:0];
                dq_next  = {dq_reg[PROD_W-2:0], q_bit};
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    phase_next = U_FIN;
                end
            end
            U_FIN:
            begin
                phase_next = U_IDLE;
            end
            default:
            begin
                phase_next = U_IDLE;
            end
        endcase
    end

    // Quotient plus one, clamped to max_seek
    assign rsp.done   = (phase_reg == U_FIN);
    assign rsp.amount = (dq_reg >= PROD_W'(ms_reg)) ? ms_reg
                                                    : dq_reg[SEEK_W-1:0] + SEEK_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        ms_reg     <= ms_next;
    end

endmodule

/* hw/rtl/stick_event_command_repeater.sv */
// A tick, button or large throttle move goes from accept to the emit state, which loads its
//   first beat into the output register; moves of axis 0 or 1 and small throttle moves wait
//   in the seek state for the bit-serial seek scaler (8 multiply steps, 24 divide steps and a
//   result state, only the result state when no scaling is needed) before any command goes out.
// One item at a time: the next is accepted once the last beat has been loaded, if there is one.
// Reset: asynchronous active-low; registers return to defaults, all axis state cleared.
module stick_event_command_repeater (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [secr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [secr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [secr_pkg::ACTION_W-1:0]       action,
    input  logic [secr_pkg::NUMBER_W-1:0]       number,
    input  logic signed [secr_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [secr_pkg::CMD_W-1:0]          command,
    output logic [secr_pkg::SEEK_W-1:0]         seek_seconds,
    output logic [secr_pkg::VOL_W-1:0]          volume,
    output logic                                last
);
    import secr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEEK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    function automatic logic [CMD_W-1:0] map_code(input logic [MAP_W-1:0] m,
                                                  input logic [2:0] slot);
        logic [4:0] base;
        base = 5'(slot) * 5'd3;
        return m[base +: CMD_W];
    endfunction

    // Configuration
    logic [THR_W-1:0]   threshold_reg, threshold_next;
    logic [TIME_W-1:0]  wait_ms_reg, wait_ms_next;
    logic [TIME_W-1:0]  repeat_ms_reg, repeat_ms_next;
    logic [SEEK_W-1:0]  max_seek_reg, max_seek_next;
    logic [MAP_W-1:0]   action_map_reg, action_map_next;

    // Block state
    state_t                    state_reg, state_next;
    logic                      trig_reg [2];
    logic                      trig_next [2];
    logic signed [VALUE_W-1:0] pos_reg [2];
    logic signed [VALUE_W-1:0] pos_next [2];
    logic [TIME_W-1:0]         hold_reg [2];
    logic [TIME_W-1:0]         hold_next [2];
    logic signed [VALUE_W-1:0] throttle_reg, throttle_next;
    logic [SEEK_W-1:0]         seek_amount_reg, seek_amount_next;
    logic [TIME_W-1:0]         idle_reg, idle_next;
    logic [CMD_W-1:0]          pend_reg [2];
    logic [CMD_W-1:0]          pend_next [2];
    logic [VOL_W-1:0]          vol_reg, vol_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]   command_reg, command_next;
    logic [SEEK_W-1:0]  seek_reg, seek_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;
    logic               last_reg, last_next;

    // Decode of the incoming beat
    logic                      accept;
    logic [VALUE_W-1:0]        mag;
    logic [VALUE_W-1:0]        thr_ext;
    logic                      above;
    logic                      below;
    logic signed [VALUE_W:0]   thr_diff;
    logic                      big_change;
    logic [VALUE_W-1:0]        vol_full;
    logic [TIME_W-1:0]         hold_inc [2];
    logic [TIME_W-1:0]         idle_inc;
    logic [TIME_W-1:0]         rep_period;
    logic                      rep_due;
    logic [CMD_W-1:0]          rep_code [2];
    logic [CMD_W-1:0]          axis_code;
    logic [CMD_W-1:0]          button_code;
    logic                      out_free;
    logic                      load;
    logic                      seek_start;
    seek_req_t                 seek_req;
    seek_rsp_t                 seek_rsp;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign mag      = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    assign thr_ext  = {1'b0, threshold_reg};
    assign above    = (mag > thr_ext);
    assign below    = (mag < thr_ext);
    assign thr_diff = {value[VALUE_W-1], value} - {throttle_reg[VALUE_W-1], throttle_reg};
    assign big_change = (thr_diff > (VALUE_W+1)'(THR_CHANGE))
                     || (thr_diff < -(VALUE_W+1)'(THR_CHANGE));
    assign vol_full = {1'b0, AXIS_FULL} - value;

    // A fresh trigger fires up for positive, down for negative deflection
    assign axis_code   = map_code(action_map_reg, {1'b0, number[0], value[VALUE_W-1]});
    assign button_code = map_code(action_map_reg, {1'b1, number[0], (value == 16'sd1)});

    // Tick bookkeeping and repeat check
    assign idle_inc   = (idle_reg == TIME_SAT) ? idle_reg : idle_reg + TIME_W'(1);
    assign rep_period = (repeat_ms_reg == '0) ? TIME_W'(1) : repeat_ms_reg;
    assign rep_due    = (idle_inc >= rep_period);

    for (genvar g = 0; g < 2; g++)
    begin : g_axis
        assign hold_inc[g] = (hold_reg[g] == TIME_SAT) ? hold_reg[g]
                                                       : hold_reg[g] + TIME_W'(1);
        always_comb
        begin
            rep_code[g] = CMD_NONE;
            if (trig_reg[g] && (hold_inc[g] > wait_ms_reg))
            begin
                if (pos_reg[g] > 16'sd0)
                begin
                    rep_code[g] = map_code(action_map_reg, 3'(2 * g));
                end
                else if (pos_reg[g] < 16'sd0)
                begin
                    rep_code[g] = map_code(action_map_reg, 3'(2 * g + 1));
                end
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (state_reg == S_EMIT) && out_free;

    assign seek_start = accept && (action == ACT_AXIS)
                     && ((number < AXIS_THROTTLE) || ((number == AXIS_THROTTLE) && !big_change));
    assign seek_req.mag      = mag;
    assign seek_req.thr      = threshold_reg;
    assign seek_req.max_seek = max_seek_reg;

    secr_seek u_seek (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seek_start),
        .req   (seek_req),
        .rsp   (seek_rsp)
    );

    // Configuration writes
    always_comb
    begin
        threshold_next  = threshold_reg;
        wait_ms_next    = wait_ms_reg;
        repeat_ms_next  = repeat_ms_reg;
        max_seek_next   = max_seek_reg;
        action_map_next = action_map_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  threshold_next  = cfg_data[THR_W-1:0];
                CFG_WAIT_MS:    wait_ms_next    = cfg_data[TIME_W-1:0];
                CFG_REPEAT_MS:  repeat_ms_next  = cfg_data[TIME_W-1:0];
                CFG_MAX_SEEK:   max_seek_next   = cfg_data[SEEK_W-1:0];
                CFG_ACTION_MAP: action_map_next = cfg_data[MAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Item processing and command sequencing
    always_comb
    begin
        state_next       = state_reg;
        trig_next        = trig_reg;
        pos_next         = pos_reg;
        hold_next        = hold_reg;
        throttle_next    = throttle_reg;
        seek_amount_next = seek_amount_reg;
        idle_next        = idle_reg;
        pend_next        = pend_reg;
        vol_next         = vol_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next[0] = CMD_NONE;
                    pend_next[1] = CMD_NONE;
                    // only a throttle move carries a volume level
                    vol_next     = '0;
                    case (action)
                        ACT_AXIS:
                        begin
                            idle_next = '0;
                            if (number == AXIS_THROTTLE)
                            begin
                                if (big_change)
                                begin
                                    throttle_next = value;
                                    vol_next      = vol_full[VALUE_W-1:VALUE_W-VOL_W];
                                    pend_next[0]  = CMD_VOLUME;
                                    state_next    = S_EMIT;
                                end
                                else
                                begin
                                    state_next = S_SEEK;
                                end
                            end
                            else if (number < AXIS_THROTTLE)
                            begin
                                pos_next[number[0]] = value;
                                if (above && !trig_reg[number[0]])
                                begin
                                    trig_next[number[0]] = 1'b1;
                                    hold_next[number[0]] = '0;
                                    pend_next[0]         = axis_code;
                                end
                                else if (below)
                                begin
                                    trig_next[number[0]] = 1'b0;
                                end
                                state_next = S_SEEK;
                            end
                        end
                        ACT_BUTTON:
                        begin
                            idle_next = '0;
                            if ((number < AXIS_THROTTLE) && (button_code != CMD_NONE))
                            begin
                                pend_next[0] = button_code;
                                state_next   = S_EMIT;
                            end
                        end
                        ACT_TICK:
                        begin
                            hold_next[0] = hold_inc[0];
                            hold_next[1] = hold_inc[1];
                            idle_next    = idle_inc;
                            if (rep_due)
                            begin
                                idle_next = '0;
                                // compact the two repeat codes, skipping empty slots
                                if (rep_code[0] != CMD_NONE)
                                begin
                                    pend_next[0] = rep_code[0];
                                    pend_next[1] = rep_code[1];
                                end
                                else
                                begin
                                    pend_next[0] = rep_code[1];
                                end
                                if ((rep_code[0] != CMD_NONE) || (rep_code[1] != CMD_NONE))
                                begin
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEEK:
            begin
                if (seek_rsp.done)
                begin
                    seek_amount_next = seek_rsp.amount;
                    state_next = (pend_reg[0] != CMD_NONE) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    pend_next[0] = pend_reg[1];
                    pend_next[1] = CMD_NONE;
                    if (pend_reg[1] == CMD_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        command_next   = command_reg;
        seek_next      = seek_reg;
        volume_next    = volume_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            command_next   = pend_reg[0];
            seek_next      = ((pend_reg[0] == CMD_SEEK_FWD) || (pend_reg[0] == CMD_SEEK_BACK))
                             ? seek_amount_reg : '0;
            volume_next    = (pend_reg[0] == CMD_VOLUME) ? vol_reg : '0;
            last_next      = (pend_reg[1] == CMD_NONE);
        end
    end

    assign out_valid    = out_valid_reg;
    assign command      = command_reg;
    assign seek_seconds = seek_reg;
    assign volume       = volume_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RST;
            wait_ms_reg     <= WAIT_MS_RST;
            repeat_ms_reg   <= REPEAT_MS_RST;
            max_seek_reg    <= MAX_SEEK_RST;
            action_map_reg  <= ACTION_MAP_RST;
            state_reg       <= S_IDLE;
            trig_reg[0]     <= 1'b0;
            trig_reg[1]     <= 1'b0;
            pos_reg[0]      <= '0;
            pos_reg[1]      <= '0;
            hold_reg[0]     <= '0;
            hold_reg[1]     <= '0;
            throttle_reg    <= '0;
            seek_amount_reg <= SEEK_W'(1);
            idle_reg        <= '0;
            pend_reg[0]     <= CMD_NONE;
            pend_reg[1]     <= CMD_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            threshold_reg   <= threshold_next;
            wait_ms_reg     <= wait_ms_next;
            repeat_ms_reg   <= repeat_ms_next;
            max_seek_reg    <= max_seek_next;
            action_map_reg  <= action_map_next;
            state_reg       <= state_next;
            trig_reg        <= trig_next;
            pos_reg         <= pos_next;
            hold_reg        <= hold_next;
            throttle_reg    <= throttle_next;
            seek_amount_reg <= seek_amount_next;
            idle_reg        <= idle_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_reg     <= vol_next;
        command_reg <= command_next;
        seek_reg    <= seek_next;
        volume_reg  <= volume_next;
        last_reg    <= last_next;
    end

`ifndef SYNTHESIS
    // The scaler only answers while the sequencer waits for it
    a_seek_done_in_seek: assert property (@(posedge clk) disable iff (!rst_n)
        seek_rsp.done |-> (state_reg == S_SEEK))
        else $error("seek scaler finished outside the seek wait");

    // The emit state always has a command to send
    a_emit_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pend_reg[0] != CMD_NONE))
        else $error("emit state without a pending command");

    // A beat on the output never carries the empty code
    a_out_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (command_reg != CMD_NONE))
        else $error("output beat with empty command");

    // Loading the final beat of an item returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (pend_reg[1] == CMD_NONE)) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after the final beat");

    // Seek amount never drops to zero
    a_seek_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seek_amount_reg != '0)
        else $error("seek amount is zero");
`endif

endmodule

/* tb/stick_event_command_repeater_tb.sv */
// Self-checking testbench of the stick event command repeater.
module stick_event_command_repeater_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import secr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 85;
    localparam int NUM_PHASES     = 8;
    localparam int VOL_DIV        = 64;

    // Item kind that the block ignores entirely
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One command beat as it leaves the block
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEEK_W-1:0] seek;
        logic [VOL_W-1:0]  vol;
        logic              last;
    } cmd_beat_t;

    // Command predictor and result checker
    class repeater_scoreboard;
        int               thr;
        int               hold_need;
        int               repeat_period;
        int               seek_cap;
        logic [MAP_W-1:0] code_map;
        bit               axis_armed[2];
        int               axis_pos[2];
        int               axis_hold[2];
        int               throttle_ref;
        int               seek_amt;
        int               idle_ms;
        cmd_beat_t        burst[$];
        cmd_beat_t        pending_cmds[$];
        int               beats_checked;
        int               items_seen;
        int               volume_beats;
        int               seek_beats;
        int               fail_count;

        function new();
            thr           = THRESHOLD_RST;
            hold_need     = WAIT_MS_RST;
            repeat_period = REPEAT_MS_RST;
            seek_cap      = MAX_SEEK_RST;
            code_map      = ACTION_MAP_RST;
            for (int i = 0; i < 2; i++)
            begin
                axis_armed[i] = 1'b0;
                axis_pos[i]   = 0;
                axis_hold[i]  = 0;
            end
            throttle_ref  = 0;
            seek_amt      = 1;
            idle_ms       = 0;
            beats_checked = 0;
            items_seen    = 0;
            volume_beats  = 0;
            seek_beats    = 0;
            fail_count    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD:  thr           = data[THR_W-1:0];
                CFG_WAIT_MS:    hold_need     = data[TIME_W-1:0];
                CFG_REPEAT_MS:  repeat_period = data[TIME_W-1:0];
                CFG_MAX_SEEK:   seek_cap      = data[SEEK_W-1:0];
                CFG_ACTION_MAP: code_map      = data[MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CMD_W-1:0] map_code(int slot);
            return code_map[slot * CMD_W +: CMD_W];
        endfunction

        // Seek amount: excess over threshold scaled to the seek cap
        function int scale_seek(int mag);
            int cap;
            int q;
            cap = (seek_cap == 0) ? 1 : seek_cap;
            if (mag <= thr)
                return 1;
            if (thr >= int'(AXIS_FULL))
                return cap;
            q = 1 + (mag - thr) * (cap - 1) / (int'(AXIS_FULL) - thr);
            return (q > cap) ? cap : q;
        endfunction

        // Code 0 issues nothing; at most two beats per item
        function void add_beat(logic [CMD_W-1:0] code, int vol);
            cmd_beat_t b;
            if (code == CMD_NONE || burst.size() >= 2)
                return;
            b.command = code;
            b.seek    = (code == CMD_SEEK_FWD || code == CMD_SEEK_BACK) ? SEEK_W'(seek_amt)
                                                                        : '0;
            b.vol     = (code == CMD_VOLUME) ? VOL_W'(vol) : '0;
            b.last    = 1'b0;
            burst.push_back(b);
        endfunction

        // Accepted input beat: advance the state and queue its commands
        function void take_event(logic [ACTION_W-1:0] act, logic [NUMBER_W-1:0] num,
                                 logic signed [VALUE_W-1:0] val);
            int v;
            int mag;
            int d;
            int rp;
            bit hit;
            v   = val;
            mag = (v < 0) ? -v : v;
            items_seen++;
            burst.delete();
            case (act)
                ACT_AXIS:
                begin
                    idle_ms = 0;
                    if (num == AXIS_THROTTLE)
                    begin
                        d = v - throttle_ref;
                        if (d < 0)
                            d = -d;
                        if (d > THR_CHANGE)
                        begin
                            throttle_ref = v;
                            add_beat(CMD_VOLUME, (int'(AXIS_FULL) - v) / VOL_DIV);
                        end
                        else
                            seek_amt = scale_seek(mag);
                    end
                    else if (num < 2)
                    begin
                        hit = 1'b0;
                        axis_pos[num] = v;
                        if (mag > thr && !axis_armed[num])
                        begin
                            axis_armed[num] = 1'b1;
                            axis_hold[num]  = 0;
                            hit = 1'b1;
                        end
                        else if (mag < thr)
                            axis_armed[num] = 1'b0;
                        seek_amt = scale_seek(mag);
                        if (hit)
                        begin
                            if (v > thr)
                                add_beat(map_code(num * 2), 0);
                            else if (v < -thr)
                                add_beat(map_code(num * 2 + 1), 0);
                        end
                    end
                end
                ACT_BUTTON:
                begin
                    idle_ms = 0;
                    if (num < 2)
                        add_beat(map_code(4 + num * 2 + ((v == 1) ? 1 : 0)), 0);
                end
                ACT_TICK:
                begin
                    rp = (repeat_period == 0) ? 1 : repeat_period;
                    for (int i = 0; i < 2; i++)
                        if (axis_hold[i] < int'(TIME_SAT))
                            axis_hold[i]++;
                    if (idle_ms < int'(TIME_SAT))
                        idle_ms++;
                    if (idle_ms >= rp)
                    begin
                        idle_ms = 0;
                        for (int i = 0; i < 2; i++)
                        begin
                            if (!axis_armed[i] || axis_hold[i] <= hold_need)
                                continue;
                            if (axis_pos[i] > 0)
                                add_beat(map_code(i * 2), 0);
                            else if (axis_pos[i] < 0)
                                add_beat(map_code(i * 2 + 1), 0);
                        end
                    end
                end
                default: ;
            endcase
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                pending_cmds.push_back(burst[i]);
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s", $time, msg);
        endfunction

        // Accepted output beat: compare with the oldest expected command
        function void check_result(cmd_beat_t got);
            cmd_beat_t want;
            if (pending_cmds.size() == 0)
            begin
                note_failure($sformatf("unexpected beat cmd=%0d seek=%0d vol=%0d last=%0d",
                                       got.command, got.seek, got.vol, got.last));
                return;
            end
            want = pending_cmds.pop_front();
            beats_checked++;
            if (want.command == CMD_VOLUME)
                volume_beats++;
            if (want.command == CMD_SEEK_FWD || want.command == CMD_SEEK_BACK)
                seek_beats++;
            if (got.command !== want.command || got.seek !== want.seek ||
                got.vol !== want.vol || got.last !== want.last)
                note_failure($sformatf({"mismatch: expected cmd=%0d seek=%0d vol=%0d last=%0d,",
                                        " got cmd=%0d seek=%0d vol=%0d last=%0d"},
                                       want.command, want.seek, want.vol, want.last,
                                       got.command, got.seek, got.vol, got.last));
        endfunction

        function void check_drained();
            if (pending_cmds.size() != 0)
            begin
                fail_count++;
                $display("%0d expected command beats never arrived", pending_cmds.size());
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [ACTION_W-1:0]          action = '0;
    logic [NUMBER_W-1:0]          number = '0;
    logic signed [VALUE_W-1:0]    value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [CMD_W-1:0]             command;
    logic [SEEK_W-1:0]            seek_seconds;
    logic [VOL_W-1:0]             volume;
    logic                         last;

    repeater_scoreboard sb = new();
    bit in_steady  = 1'b0;
    bit out_steady = 1'b0;
    int out_hold_left = 0;
    int quiet_cycles = 0;
    int settings_used = 0;

    stick_event_command_repeater u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .number       (number),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command      (command),
        .seek_seconds (seek_seconds),
        .volume       (volume),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure: mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (out_hold_left > 0)
        begin
            out_stall     <= 1'b1;
            out_hold_left <= out_hold_left - 1;
        end
        else if (!out_steady && $urandom_range(0, 99) < 30)
        begin
            out_stall     <= 1'b1;
            out_hold_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                          : $urandom_range(5, 50);
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_event(action, number, value);
            if (out_valid && !out_stall)
                sb.check_result('{command, seek_seconds, volume, last});
        end
    end

    // Watchdog on cycles without any beat or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("stick_event_command_repeater_tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Axis position: extremes, around the threshold, below it, or anywhere
    function automatic logic [VALUE_W-1:0] pick_position(int thr);
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0: v = 32767;
            1: v = -32768;
            2, 3: v = thr + $urandom_range(0, 2) - 1;
            4: v = -(thr + $urandom_range(0, 2) - 1);
            5: v = (thr > 0) ? $urandom_range(0, thr - 1) : 0;
            default: v = $urandom_range(0, 65535);
        endcase
        if (r == 5 && $urandom_range(0, 1))
            v = -v;
        return v[VALUE_W-1:0];
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] a, input logic [NUMBER_W-1:0] n,
                             input logic [VALUE_W-1:0] v);
        int gap;
        action   <= a;
        number   <= n;
        value    <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected beat has come out
    task automatic drain_outputs(input int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_cmds.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Write all five registers, one per cycle, enable held high throughout
    task automatic program_regs(input int thr, input int hold, input int rp, input int cap,
                                input int map);
        cfg_idx_t              order[5];
        logic [CFG_DATA_W-1:0] vals[5];
        order = '{CFG_THRESHOLD, CFG_WAIT_MS, CFG_REPEAT_MS, CFG_MAX_SEEK, CFG_ACTION_MAP};
        vals  = '{thr, hold, rp, cap, map};
        foreach (order[i])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_ticks(input int k, inout int counted);
        repeat (k)
            send_item(ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 65535));
        counted += k;
    endtask

    // Random traffic: axis moves (some followed by tick runs), ticks, throttle, buttons, ignored items
    task automatic run_random(input int n_items);
        int counted;
        int r;
        int v;
        counted = 0;
        while (counted < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                send_item(ACT_AXIS, $urandom_range(0, 1), pick_position(sb.thr));
                counted++;
                send_ticks($urandom_range(1, 24), counted);
            end
            else if (r < 52)
                send_ticks(1, counted);
            else if (r < 68)
            begin
                send_item(ACT_AXIS, $urandom_range(0, 1), pick_position(sb.thr));
                counted++;
            end
            else if (r < 78)
            begin
                case ($urandom_range(0, 3))
                    0: v = sb.throttle_ref + 200;
                    1: v = sb.throttle_ref - 201;
                    2: v = sb.throttle_ref + $urandom_range(0, 400) - 200;
                    default: v = $urandom_range(0, 65535);
                endcase
                send_item(ACT_AXIS, AXIS_THROTTLE, v[VALUE_W-1:0]);
                counted++;
            end
            else if (r < 90)
            begin
                case ($urandom_range(0, 2))
                    0: v = 1;
                    1: v = 0;
                    default: v = $urandom_range(0, 65535);
                endcase
                send_item(ACT_BUTTON, $urandom_range(0, 1), v[VALUE_W-1:0]);
                counted++;
            end
            else
            begin
                // Ignored traffic: out-of-range axes and buttons, unused kind
                case ($urandom_range(0, 2))
                    0: send_item(ACT_AXIS, $urandom_range(3, 255), $urandom_range(0, 65535));
                    1: send_item(ACT_BUTTON, $urandom_range(2, 255), $urandom_range(0, 65535));
                    default: send_item(ACT_UNUSED, $urandom_range(0, 255),
                                       $urandom_range(0, 65535));
                endcase
            end
            if ($urandom_range(0, 59) == 0)
                drain_outputs(0);
        end
    endtask

    initial
    begin
        int thr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: triggers, threshold edges, throttle, buttons, ignored items
        send_item(ACT_AXIS, 0, 16'sd32767);
        send_item(ACT_AXIS, 0, -16'sd32768);
        send_item(ACT_AXIS, 0, 16'sd12000);
        send_item(ACT_AXIS, 0, 16'sd0);
        send_item(ACT_AXIS, 0, -16'sd20000);
        send_item(ACT_AXIS, 1, 16'sd12001);
        send_item(ACT_AXIS, AXIS_THROTTLE, 16'sd32767);
        send_item(ACT_AXIS, AXIS_THROTTLE, 16'sd32700);
        send_item(ACT_AXIS, AXIS_THROTTLE, -16'sd32768);
        send_item(ACT_AXIS, 3, 16'sd32767);
        send_item(ACT_AXIS, 255, -16'sd1);
        send_item(ACT_BUTTON, 0, 16'sd1);
        send_item(ACT_BUTTON, 0, 16'sd0);
        send_item(ACT_BUTTON, 1, 16'sd1);
        send_item(ACT_BUTTON, 1, -16'sd1);
        send_item(ACT_BUTTON, 2, 16'sd1);
        send_item(ACT_BUTTON, 255, 16'sd1);
        send_item(ACT_UNUSED, 0, 16'sd32767);
        send_item(ACT_UNUSED, 255, -16'sd32768);
        send_item(ACT_AXIS, 1, -16'sd12000);
        send_item(ACT_TICK, 255, -16'sd1);
        drain_outputs(SETTLE_CYCLES);

        // Directed: short hold and repeat so both axes auto-repeat
        program_regs(THRESHOLD_RST, 2, 2, MAX_SEEK_RST, ACTION_MAP_RST);
        repeat (5)
            send_item(ACT_TICK, 0, 16'sd0);
        drain_outputs(SETTLE_CYCLES);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            thr = $urandom_range(1, 32766);
            in_steady  = (p == 2 || p == 6);
            out_steady = (p == 3 || p == 6);
            case (p)
                0: program_regs(1000, 0, 0, 0, $urandom_range(0, 24'hFFFFFF));
                1: program_regs(AXIS_FULL, TIME_SAT, TIME_SAT, 255, 24'hFFFFFF);
                2: program_regs(0, 3, 1, 255, $urandom_range(0, 24'hFFFFFF));
                3: program_regs(thr, $urandom_range(0, 20), $urandom_range(1, 8),
                                $urandom_range(1, 255), $urandom_range(0, 24'hFFFFFF));
                4: program_regs(THRESHOLD_RST, WAIT_MS_RST, REPEAT_MS_RST, MAX_SEEK_RST,
                                ACTION_MAP_RST);
                5: program_regs(thr, $urandom_range(0, 10), $urandom_range(1, 5), 1, 0);
                6: program_regs(20000, 5, 2, 128, 24'hFFFFFF);
                default: program_regs(thr, $urandom_range(0, 30), $urandom_range(1, 10),
                                      $urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF));
            endcase
            run_random(PHASE_ITEMS);
            drain_outputs(SETTLE_CYCLES);
        end

        sb.check_drained();
        $display("covered %0d input beats under %0d register settings",
                 sb.items_seen, settings_used);
        $display("checked %0d command beats (%0d volume, %0d seek)",
                 sb.beats_checked, sb.volume_beats, sb.seek_beats);
        if (sb.fail_count == 0)
            $display("stick_event_command_repeater_tb: PASS");
        else
            $display("stick_event_command_repeater_tb: FAIL");
        $finish;
    end

endmodule
